[rtl/brainfuck_interpreter_core_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the interpreter core
// Shared helpers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BRAINFUCK_INTERPRETER_CORE_UNIT_DEFINES_SVH
`define BRAINFUCK_INTERPRETER_CORE_UNIT_DEFINES_SVH

// Property checked outside reset.
`define BFI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BFI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bfi_pkg.sv]
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared types, codes and the symbol encoder of the interpreter core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfi_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_START  = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_SUPPLY = 3'd4,
    CMD_BAD    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    SYM_RIGHT = 4'd0,
    SYM_LEFT  = 4'd1,
    SYM_INC   = 4'd2,
    SYM_DEC   = 4'd3,
    SYM_OUT   = 4'd4,
    SYM_IN    = 4'd5,
    SYM_OPEN  = 4'd6,
    SYM_CLOSE = 4'd7,
    SYM_NL    = 4'd8,
    SYM_BAD   = 4'd9
  } sym_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OUT     = 3'd1,
    ST_WAIT    = 3'd2,
    ST_END     = 3'd3,
    ST_SYNTAX  = 3'd4,
    ST_BRACKET = 3'd5,
    ST_FULL    = 3'd6,
    ST_REFUSED = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_WAIT = 2'd2,
    MODE_HALT = 2'd3
  } mode_t;

  // Raw command codes on the input channel.
  localparam logic [2:0] RAW_CLEAR  = 3'd0;
  localparam logic [2:0] RAW_LOAD   = 3'd1;
  localparam logic [2:0] RAW_START  = 3'd2;
  localparam logic [2:0] RAW_STEP   = 3'd3;
  localparam logic [2:0] RAW_SUPPLY = 3'd4;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // One classified item between front and back.
  typedef struct packed {
    cmd_t       kind;
    sym_t       sym;
    logic [7:0] val;
  } op_t;

  function automatic sym_t encode_symbol(input logic [7:0] c);
    sym_t s;
    begin
      case (c)
        CH_RIGHT: s = SYM_RIGHT;
        CH_LEFT:  s = SYM_LEFT;
        CH_INC:   s = SYM_INC;
        CH_DEC:   s = SYM_DEC;
        CH_OUT:   s = SYM_OUT;
        CH_IN:    s = SYM_IN;
        CH_OPEN:  s = SYM_OPEN;
        CH_CLOSE: s = SYM_CLOSE;
        CH_NL:    s = SYM_NL;
        default:  s = SYM_BAD;
      endcase
      return s;
    end
  endfunction

endpackage

[rtl/bfi_front.sv]
// ----------------------------------------------------------------------------
// bfi_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfi_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_command,
  input  logic [7:0]       in_value,
  output logic             q_valid,
  output bfi_pkg::op_t     q_op,
  input  logic             q_pop
);

  bfi_pkg::op_t q_mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  bfi_pkg::op_t op_in;
  logic         push;

  always_comb begin
    op_in.val = in_value;
    op_in.sym = bfi_pkg::encode_symbol(in_value);
    unique case (in_command)
      bfi_pkg::RAW_CLEAR:  op_in.kind = bfi_pkg::CMD_CLEAR;
      bfi_pkg::RAW_LOAD:   op_in.kind = bfi_pkg::CMD_LOAD;
      bfi_pkg::RAW_START:  op_in.kind = bfi_pkg::CMD_START;
      bfi_pkg::RAW_STEP:   op_in.kind = bfi_pkg::CMD_STEP;
      bfi_pkg::RAW_SUPPLY: op_in.kind = bfi_pkg::CMD_SUPPLY;
      default:             op_in.kind = bfi_pkg::CMD_BAD;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

[rtl/bfi_back.sv]
// ----------------------------------------------------------------------------
// bfi_back
// Carries out queued items against the program, jump, stack and tape memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfi_back #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 32768,
  parameter int NEST_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  bfi_pkg::op_t q_op,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   out_status,
  output logic [7:0]   out_out_byte,
  output logic [11:0]  out_position
);

  localparam int AW  = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam int PCW = $clog2(PROG_DEPTH + 1);
  localparam int DW  = $clog2(TAPE_DEPTH);
  localparam int SW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int LW  = $clog2(NEST_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_EXEC  = 5'b00100,
    S_JUMP2 = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  bfi_pkg::op_t    op_r;
  bfi_pkg::mode_t  mode_r, mode_nxt;
  logic [PCW-1:0]  len_r, len_nxt;
  logic [PCW-1:0]  pc_r, pc_nxt;
  logic [DW-1:0]   dp_r, dp_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic            fault_r, fault_nxt;
  logic [AW-1:0]   fault_pos_r, fault_pos_nxt;
  logic [DW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]   jw_addr_r, jw_addr_nxt;
  logic [AW-1:0]   jw_data_r, jw_data_nxt;

  logic            ov_r, ov_nxt;
  logic [2:0]      ost_r, ost_nxt;
  logic [7:0]      obyte_r, obyte_nxt;
  logic [11:0]     opos_r, opos_nxt;

  logic [3:0]      prog_mem [PROG_DEPTH];
  logic [AW-1:0]   jump_mem [PROG_DEPTH];
  logic [AW-1:0]   stack_mem [NEST_DEPTH];
  logic [7:0]      tape_mem [TAPE_DEPTH];

  logic [3:0]      prog_q;
  logic [AW-1:0]   jump_q;
  logic [AW-1:0]   stack_q;
  logic [7:0]      tape_q;

  logic [AW-1:0]   prog_ra;
  logic [SW-1:0]   stack_ra;

  logic            prog_we;
  logic            jump_we;
  logic [AW-1:0]   jump_wa, jump_wd;
  logic            stack_we;
  logic            tape_we;
  logic [DW-1:0]   tape_wa;
  logic [7:0]      tape_wd;
  logic [PCW-1:0]  pc_inc;

  assign q_pop        = (state_r == S_IDLE) && q_valid && !ov_r;
  assign out_valid    = ov_r;
  assign out_status   = ost_r;
  assign out_out_byte = obyte_r;
  assign out_position = opos_r;

  assign prog_ra  = (pc_r < len_r) ? pc_r[AW-1:0] : '0;
  assign stack_ra = (lvl_r == '0) ? '0 : SW'(lvl_r - 1'b1);
  assign pc_inc   = pc_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    pc_nxt        = pc_r;
    dp_nxt        = dp_r;
    lvl_nxt       = lvl_r;
    fault_nxt     = fault_r;
    fault_pos_nxt = fault_pos_r;
    clr_cnt_nxt   = clr_cnt_r;
    jw_addr_nxt   = jw_addr_r;
    jw_data_nxt   = jw_data_r;
    ov_nxt        = ov_r && !out_ready;
    ost_nxt       = ost_r;
    obyte_nxt     = obyte_r;
    opos_nxt      = opos_r;
    prog_we       = 1'b0;
    jump_we       = 1'b0;
    jump_wa       = jw_addr_r;
    jump_wd       = jw_data_r;
    stack_we      = 1'b0;
    tape_we       = 1'b0;
    tape_wa       = dp_r;
    tape_wd       = 8'd0;

    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        ost_nxt   = bfi_pkg::ST_OK;
        obyte_nxt = 8'd0;
        opos_nxt  = 12'(pc_r);
        unique case (op_r.kind)
          bfi_pkg::CMD_CLEAR: begin
            len_nxt       = '0;
            lvl_nxt       = '0;
            pc_nxt        = '0;
            mode_nxt      = bfi_pkg::MODE_IDLE;
            fault_nxt     = 1'b0;
            fault_pos_nxt = '0;
            opos_nxt      = 12'd0;
          end
          bfi_pkg::CMD_LOAD: begin
            if (mode_r != bfi_pkg::MODE_IDLE) begin
              ost_nxt = bfi_pkg::ST_REFUSED;
            end else if (len_r >= PCW'(PROG_DEPTH)) begin
              ost_nxt  = bfi_pkg::ST_FULL;
              opos_nxt = 12'(len_r);
            end else begin
              opos_nxt = 12'(len_r);
              prog_we  = 1'b1;
              len_nxt  = len_r + 1'b1;
              if (op_r.sym == bfi_pkg::SYM_OPEN) begin
                if (lvl_r >= LW'(NEST_DEPTH)) begin
                  ost_nxt = bfi_pkg::ST_BRACKET;
                  if (!fault_r) begin
                    fault_nxt     = 1'b1;
                    fault_pos_nxt = len_r[AW-1:0];
                  end
                end else begin
                  stack_we = 1'b1;
                  lvl_nxt  = lvl_r + 1'b1;
                end
              end else if (op_r.sym == bfi_pkg::SYM_CLOSE) begin
                if (lvl_r == '0) begin
                  ost_nxt = bfi_pkg::ST_BRACKET;
                  if (!fault_r) begin
                    fault_nxt     = 1'b1;
                    fault_pos_nxt = len_r[AW-1:0];
                  end
                end else begin
                  // Pair both ends: open side now, close side next cycle.
                  lvl_nxt     = lvl_r - 1'b1;
                  jump_we     = 1'b1;
                  jump_wa     = stack_q;
                  jump_wd     = len_r[AW-1:0];
                  jw_addr_nxt = len_r[AW-1:0];
                  jw_data_nxt = stack_q;
                  state_nxt   = S_JUMP2;
                end
              end
            end
          end
          bfi_pkg::CMD_START: begin
            if (fault_r) begin
              ost_nxt  = bfi_pkg::ST_BRACKET;
              opos_nxt = 12'(fault_pos_r);
            end else if (lvl_r != '0) begin
              ost_nxt  = bfi_pkg::ST_BRACKET;
              opos_nxt = 12'(stack_q);
            end else begin
              // Result waits for the end of the tape sweep.
              ov_nxt      = 1'b0;
              dp_nxt      = '0;
              pc_nxt      = '0;
              mode_nxt    = bfi_pkg::MODE_RUN;
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
          end
          bfi_pkg::CMD_STEP: begin
            unique case (mode_r)
              bfi_pkg::MODE_IDLE: ost_nxt = bfi_pkg::ST_REFUSED;
              bfi_pkg::MODE_WAIT: ost_nxt = bfi_pkg::ST_WAIT;
              bfi_pkg::MODE_HALT: begin
                ost_nxt = (pc_r >= len_r) ? bfi_pkg::ST_END : bfi_pkg::ST_SYNTAX;
              end
              default: begin
                if (pc_r >= len_r) begin
                  mode_nxt = bfi_pkg::MODE_HALT;
                  ost_nxt  = bfi_pkg::ST_END;
                end else begin
                  pc_nxt = pc_inc;
                  case (prog_q)
                    bfi_pkg::SYM_RIGHT: begin
                      dp_nxt = (dp_r == DW'(TAPE_DEPTH - 1)) ? '0 : dp_r + 1'b1;
                    end
                    bfi_pkg::SYM_LEFT: begin
                      dp_nxt = (dp_r == '0) ? DW'(TAPE_DEPTH - 1) : dp_r - 1'b1;
                    end
                    bfi_pkg::SYM_INC: begin
                      tape_we = 1'b1;
                      tape_wd = tape_q + 8'd1;
                    end
                    bfi_pkg::SYM_DEC: begin
                      tape_we = 1'b1;
                      tape_wd = tape_q - 8'd1;
                    end
                    bfi_pkg::SYM_OUT: begin
                      ost_nxt   = bfi_pkg::ST_OUT;
                      obyte_nxt = tape_q;
                    end
                    bfi_pkg::SYM_IN: begin
                      pc_nxt   = pc_r;
                      mode_nxt = bfi_pkg::MODE_WAIT;
                      ost_nxt  = bfi_pkg::ST_WAIT;
                    end
                    bfi_pkg::SYM_OPEN: begin
                      if (tape_q == 8'd0) begin
                        pc_nxt = PCW'(jump_q) + 1'b1;
                      end
                    end
                    bfi_pkg::SYM_CLOSE: begin
                      if (tape_q != 8'd0) begin
                        pc_nxt = PCW'(jump_q) + 1'b1;
                      end
                    end
                    bfi_pkg::SYM_NL: begin
                    end
                    default: begin
                      pc_nxt   = pc_r;
                      mode_nxt = bfi_pkg::MODE_HALT;
                      ost_nxt  = bfi_pkg::ST_SYNTAX;
                    end
                  endcase
                end
              end
            endcase
          end
          bfi_pkg::CMD_SUPPLY: begin
            if (mode_r != bfi_pkg::MODE_WAIT) begin
              ost_nxt = bfi_pkg::ST_REFUSED;
            end else begin
              tape_we  = 1'b1;
              tape_wd  = op_r.val;
              mode_nxt = bfi_pkg::MODE_RUN;
              pc_nxt   = pc_inc;
            end
          end
          default: begin
            ost_nxt = bfi_pkg::ST_REFUSED;
          end
        endcase
      end
      S_JUMP2: begin
        jump_we   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        tape_we     = 1'b1;
        tape_wa     = clr_cnt_r;
        tape_wd     = 8'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == DW'(TAPE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          ost_nxt   = bfi_pkg::ST_OK;
          obyte_nxt = 8'd0;
          opos_nxt  = 12'd0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= bfi_pkg::MODE_IDLE;
      len_r       <= '0;
      pc_r        <= '0;
      dp_r        <= '0;
      lvl_r       <= '0;
      fault_r     <= 1'b0;
      fault_pos_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      pc_r        <= pc_nxt;
      dp_r        <= dp_nxt;
      lvl_r       <= lvl_nxt;
      fault_r     <= fault_nxt;
      fault_pos_r <= fault_pos_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_op;
    end
    clr_cnt_r <= clr_cnt_nxt;
    jw_addr_r <= jw_addr_nxt;
    jw_data_r <= jw_data_nxt;
    ost_r     <= ost_nxt;
    obyte_r   <= obyte_nxt;
    opos_r    <= opos_nxt;
  end

  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[len_r[AW-1:0]] <= op_r.sym;
    end
    prog_q <= prog_mem[prog_ra];
  end

  always_ff @(posedge clk) begin
    if (jump_we) begin
      jump_mem[jump_wa] <= jump_wd;
    end
    jump_q <= jump_mem[prog_ra];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[lvl_r[SW-1:0]] <= len_r[AW-1:0];
    end
    stack_q <= stack_mem[stack_ra];
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    tape_q <= tape_mem[dp_r];
  end

endmodule

[rtl/brainfuck_interpreter_core_unit.sv]
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core_unit
// Program loader and single-step interpreter with a local tape.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_command, in_value) carries commands:
//   clear, load symbol, start, step, supply input byte. Every command yields
//   exactly one result transfer on the output channel (out_valid/out_ready,
//   out_status, out_out_byte, out_position).
//   Most commands pass through queue pop, memory read and execute before
//   the result is valid. A load of a matching ']' writes the second jump
//   table entry while its result is on the output, hidden behind the
//   result handshake. A successful start sweeps the whole tape to zero,
//   one cell per cycle, before its result is given. The back end takes one
//   command at a time: pop, memory read, execute, then the result transfer
//   before it pops again. A two-entry queue in front takes further commands
//   while the back end works and drops in_ready only when it is full.
//   Reset empties the program, stack and fault latch and returns to idle;
//   memory contents are not cleared (start clears the tape).
//   When the receiver stalls, the result register holds, the back end stops
//   at its next command and the queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brainfuck_interpreter_core_unit #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 32768,
  parameter int NEST_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_out_byte,
  output logic [11:0] out_position
);

  // Classified command handed from front to back.
  logic         q_valid;
  logic         q_pop;
  bfi_pkg::op_t q_op;

  // Front: accept and decode, buffer up to two commands.
  bfi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_value   (in_value),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop)
  );

  // Back: execute against memories, drive the result register.
  bfi_back #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH),
    .NEST_DEPTH (NEST_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_out_byte (out_out_byte),
    .out_position (out_position)
  );

endmodule

[rtl/bfi_checker.sv]
// ----------------------------------------------------------------------------
// bfi_checker
// Port-level checks of the interpreter core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "brainfuck_interpreter_core_unit_defines.svh"

module bfi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [7:0]  out_out_byte,
  input logic [11:0] out_position
);

  property p_out_stable;
    out_valid && !out_ready |=> $stable(out_position) && $stable(out_status);
  endproperty

  property p_byte_zero;
    out_valid && (out_status != bfi_pkg::ST_OUT) |-> out_out_byte == 8'd0;
  endproperty

  `BFI_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `BFI_ASSERT(a_out_stable, clk, rst_n, p_out_stable, "result changed while stalled")
  `BFI_ASSERT(a_byte_zero, clk, rst_n, p_byte_zero, "byte without output status")
  `BFI_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind brainfuck_interpreter_core_unit bfi_checker u_bfi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_out_byte (out_out_byte),
  .out_position (out_position)
);
